@@ hw/rtl/ost_pkg.sv @@
// Package for the owned slot table: opcodes, status codes, FSM states
// and stream field widths. No dependencies.
package ost_pkg;

    localparam int OP_W     = 2;
    localparam int IDX_W    = 8;
    localparam int OWNER_W  = 32;
    localparam int PAY_W    = 64;
    localparam int STATUS_W = 3;

    localparam int IN_BITS  = OP_W + IDX_W + OWNER_W + PAY_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STATUS_W + IDX_W + PAY_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_STORE   = 2'd0,
        OP_READ    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_FIND    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_SLOT   = 3'd1,
        ST_FOREIGN   = 3'd2,
        ST_OCCUPIED  = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_NONE_FREE = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_RELEASE,
        S_FIND,
        S_HOLD
    } t_state;

endpackage

@@ hw/rtl/owned_slot_table.sv @@
// Owned slot table top level: command decode, tag and payload memories,
// occupancy/ownership flags, release and find sweeps, output register.
// Depends on ost_pkg.
//
// One command per beat, one result beat per command, handled one at a time.
// Store and read do one tag/payload memory read, then check and write back.
// Release sweeps the single read port of the owner-tag memory one slot per
// cycle. Find-free scans the per-slot flags one slot per cycle and stops at
// the lowest free slot, or at the last slot when none is free. A result that
// cannot be registered while the output stalls waits in S_HOLD. Occupied and
// owned flags sit in flip-flops cleared by reset, so no memory clearing pass
// is needed; a tag memory entry is only used while its owned flag is set.
module owned_slot_table #(
    parameter int SLOTS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // operation[1:0], slot_index[9:2], owner_id[41:10], payload[105:42]
    input  logic [ost_pkg::IN_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // status[2:0], slot_index_out[10:3], payload_out[74:11]
    output logic [ost_pkg::OUT_W-1:0] o_m_tdata
);
    import ost_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [OWNER_W-1:0] mem_tag [SLOTS];
    logic [PAY_W-1:0]   mem_pay [SLOTS];

    t_state r_state, n_state;

    logic [SLOTS-1:0]   r_occ;
    logic [SLOTS-1:0]   r_own;
    t_op                r_op;
    logic [IDX_W-1:0]   r_idx;
    logic [OWNER_W-1:0] r_who;
    logic [PAY_W-1:0]   r_pay;
    logic               r_exists;
    logic [CW-1:0]      r_cnt;
    logic [OWNER_W-1:0] r_tag_q;
    logic [PAY_W-1:0]   r_pay_q;
    logic               r_rd_on;
    logic [AW-1:0]      r_rd_addr;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [IDX_W-1:0]   r_out_idx;
    logic [PAY_W-1:0]   r_out_pay;
    t_status            r_pnd_status;
    logic [IDX_W-1:0]   r_pnd_idx;
    logic [PAY_W-1:0]   r_pnd_pay;

    t_op                w_op;
    logic [IDX_W-1:0]   w_idx;
    logic [OWNER_W-1:0] w_who;
    logic [PAY_W-1:0]   w_pay;
    logic               w_accept;
    logic               w_out_free;
    logic [AW-1:0]      w_addr;
    logic [AW-1:0]      w_rd_addr;
    logic [AW-1:0]      w_cnt_addr;
    logic               w_issue;
    logic               w_rel_match;
    logic [OWNER_W-1:0] w_tag_eff;

    logic               res_done;
    t_status            res_status;
    logic [IDX_W-1:0]   res_where;
    logic [PAY_W-1:0]   res_data;
    logic               res_wr;
    logic               res_step;

    assign w_op  = t_op'(i_s_tdata[OP_W-1:0]);
    assign w_idx = i_s_tdata[OP_W +: IDX_W];
    assign w_who = i_s_tdata[OP_W+IDX_W +: OWNER_W];
    assign w_pay = i_s_tdata[OP_W+IDX_W+OWNER_W +: PAY_W];

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    assign w_addr     = r_idx[AW-1:0];
    assign w_cnt_addr = r_cnt[AW-1:0];
    assign w_issue    = (r_state == S_RELEASE) && (r_cnt < CW'(SLOTS));
    assign w_rd_addr  = (r_state == S_RELEASE) ? w_cnt_addr : w_idx[AW-1:0];

    assign w_tag_eff   = r_own[r_rd_addr] ? r_tag_q : '0;
    assign w_rel_match = (r_state == S_RELEASE) && r_rd_on && (w_tag_eff == r_who);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        OP_STORE, OP_READ: n_state = S_LOOK;
                        OP_RELEASE:        n_state = S_RELEASE;
                        OP_FIND:           n_state = S_FIND;
                        default:           n_state = S_LOOK;
                    endcase
                end
            end
            S_LOOK, S_RELEASE, S_FIND: begin
                if (res_done) begin
                    n_state = w_out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        res_done   = 1'b0;
        res_status = ST_OK;
        res_where  = '0;
        res_data   = '0;
        res_wr     = 1'b0;
        res_step   = 1'b0;
        unique case (r_state)
            S_LOOK: begin
                res_done  = 1'b1;
                res_where = r_idx;
                if (!r_exists) begin
                    res_status = ST_NO_SLOT;
                end else if (r_op == OP_STORE) begin
                    if (r_own[w_addr] && (r_tag_q != r_who)) begin
                        res_status = ST_FOREIGN;
                    end else if (r_occ[w_addr]) begin
                        res_status = ST_OCCUPIED;
                    end else begin
                        res_wr = 1'b1;
                    end
                end else if (!r_occ[w_addr]) begin
                    res_status = ST_EMPTY;
                end else begin
                    res_data = r_pay_q;
                end
            end
            S_RELEASE: begin
                res_done = (r_cnt == CW'(SLOTS));
            end
            S_FIND: begin
                if (!r_occ[w_cnt_addr] && !r_own[w_cnt_addr]) begin
                    res_done  = 1'b1;
                    res_where = IDX_W'(r_cnt);
                end else if (r_cnt == CW'(SLOTS - 1)) begin
                    res_done   = 1'b1;
                    res_status = ST_NONE_FREE;
                end else begin
                    res_step = 1'b1;
                end
            end
            default: res_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_own       <= '0;
            r_rd_on     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_on <= w_issue;
            if (res_wr) begin
                r_occ[w_addr] <= 1'b1;
                r_own[w_addr] <= (r_who != '0);
            end
            if (w_rel_match) begin
                r_occ[r_rd_addr] <= 1'b0;
                r_own[r_rd_addr] <= 1'b0;
            end
            if ((res_done || (r_state == S_HOLD)) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= w_op;
            r_idx    <= w_idx;
            r_who    <= w_who;
            r_pay    <= w_pay;
            r_exists <= (9'(w_idx) < 9'(SLOTS));
            r_cnt    <= '0;
        end else if (w_issue || res_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
        r_rd_addr <= w_cnt_addr;
        if (res_done) begin
            r_pnd_status <= res_status;
            r_pnd_idx    <= res_where;
            r_pnd_pay    <= res_data;
        end
        if (res_done && w_out_free) begin
            r_out_status <= res_status;
            r_out_idx    <= res_where;
            r_out_pay    <= res_data;
        end else if ((r_state == S_HOLD) && w_out_free) begin
            r_out_status <= r_pnd_status;
            r_out_idx    <= r_pnd_idx;
            r_out_pay    <= r_pnd_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_wr) begin
            mem_tag[w_addr] <= r_who;
            mem_pay[w_addr] <= r_pay;
        end
        r_tag_q <= mem_tag[w_rd_addr];
        r_pay_q <= mem_pay[w_idx[AW-1:0]];
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_W - OUT_BITS)'(0), r_out_pay, r_out_idx, r_out_status};

endmodule

@@ hw/rtl/ost_checker.sv @@
// Port-level checker for owned_slot_table, bound to the top level below.
// Depends on ost_pkg.
module ost_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic [ost_pkg::IN_W-1:0]  i_s_tdata,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [ost_pkg::OUT_W-1:0] o_m_tdata
);
    import ost_pkg::*;

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    a_payload_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[STATUS_W-1:0] != ST_OK) |->
            (o_m_tdata[STATUS_W+IDX_W +: PAY_W] == '0))
        else $error("payload on failed command");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second command taken while busy");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind owned_slot_table ost_checker u_ost_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

@@ tb/owned_slot_table_test.sv @@
// Self-checking stream testbench for owned_slot_table: directed, full-table and
// random command phases checked beat by beat against an in-bench table predictor.
// Depends on ost_pkg and the owned_slot_table RTL.
module owned_slot_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ost_pkg::*;

    localparam int SLOTS        = 64;
    localparam int STALL_MAX    = 14;
    localparam int DRAIN_CYCLES = SLOTS + 16;
    localparam int IDLE_LIMIT   = 2000;

    typedef struct packed {
        t_status            status;
        logic [IDX_W-1:0]   slot;
        logic [PAY_W-1:0]   payload;
    } t_result;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    // operation[1:0], slot_index[9:2], owner_id[41:10], payload[105:42]
    logic [IN_W-1:0]   i_s_tdata  = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    // status[2:0], slot_index_out[10:3], payload_out[74:11]
    logic [OUT_W-1:0]  o_m_tdata;

    logic              slot_busy  [SLOTS];
    logic [OWNER_W-1:0] slot_owner [SLOTS];
    logic [PAY_W-1:0]  slot_data  [SLOTS];

    t_result           expected_results [$];
    t_result           want_result;
    int                fail_count  = 0;
    int                idle_cycles = 0;
    bit                tx_calm     = 1'b0;
    bit                rx_calm     = 1'b0;

    always #5 i_clk = ~i_clk;

    owned_slot_table #(
        .SLOTS(SLOTS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    function automatic t_result table_apply(t_op op, logic [IDX_W-1:0] idx,
                                            logic [OWNER_W-1:0] who,
                                            logic [PAY_W-1:0] data);
        t_result r;
        bit      found;
        r.status  = ST_OK;
        r.slot    = '0;
        r.payload = '0;
        found     = 1'b0;
        case (op)
            OP_STORE, OP_READ: begin
                r.slot = idx;
                if (idx >= SLOTS) begin
                    r.status = ST_NO_SLOT;
                end else if (op == OP_STORE) begin
                    if (slot_owner[idx] != who && slot_owner[idx] != '0) begin
                        r.status = ST_FOREIGN;
                    end else if (slot_busy[idx]) begin
                        r.status = ST_OCCUPIED;
                    end else begin
                        slot_owner[idx] = who;
                        slot_data[idx]  = data;
                        slot_busy[idx]  = 1'b1;
                    end
                end else if (!slot_busy[idx]) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.payload = slot_data[idx];
                end
            end
            OP_RELEASE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_owner[i] == who) begin
                        slot_busy[i]  = 1'b0;
                        slot_owner[i] = '0;
                    end
                end
            end
            default: begin
                r.status = ST_NONE_FREE;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!found && !slot_busy[i] && slot_owner[i] == '0) begin
                        found    = 1'b1;
                        r.status = ST_OK;
                        r.slot   = IDX_W'(i);
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_cmd(t_op op, logic [IDX_W-1:0] idx, logic [OWNER_W-1:0] who,
                            logic [PAY_W-1:0] data);
        int              gap;
        logic [IN_W-1:0] word;
        gap  = tx_calm ? 0 : $urandom_range(0, STALL_MAX);
        word = '0;
        word[OP_W-1:0]                   = op;
        word[OP_W +: IDX_W]              = idx;
        word[OP_W+IDX_W +: OWNER_W]      = who;
        word[OP_W+IDX_W+OWNER_W +: PAY_W] = data;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        do @(posedge i_clk); while (!o_s_tready);
        expected_results.push_back(table_apply(op, idx, who, data));
    endtask

    task automatic test_directed();
        send_cmd(OP_FIND,    8'd0,   32'd0,          64'd0);
        send_cmd(OP_STORE,   8'd0,   32'hFFFF_FFFF,  {64{1'b1}});
        send_cmd(OP_STORE,   8'd63,  32'd1,          64'd0);
        send_cmd(OP_STORE,   8'd64,  32'd1,          64'h1234);
        send_cmd(OP_STORE,   8'd255, 32'd1,          64'h5678);
        send_cmd(OP_READ,    8'd255, 32'd0,          64'd0);
        send_cmd(OP_READ,    8'd64,  32'd0,          64'd0);
        send_cmd(OP_READ,    8'd5,   32'd0,          64'd0);
        send_cmd(OP_READ,    8'd0,   32'd0,          64'd0);
        send_cmd(OP_READ,    8'd63,  32'd0,          64'd0);
        send_cmd(OP_STORE,   8'd0,   32'd1,          64'hDEAD);
        send_cmd(OP_STORE,   8'd0,   32'hFFFF_FFFF,  64'hBEEF);
        send_cmd(OP_STORE,   8'd1,   32'd0,          64'hA5A5_5A5A_C3C3_3C3C);
        send_cmd(OP_STORE,   8'd1,   32'd7,          64'h77);
        send_cmd(OP_FIND,    8'd0,   32'd0,          64'd0);
        send_cmd(OP_RELEASE, 8'd0,   32'd0,          64'd0);
        send_cmd(OP_READ,    8'd1,   32'd0,          64'd0);
        send_cmd(OP_FIND,    8'd0,   32'd0,          64'd0);
        send_cmd(OP_RELEASE, 8'd0,   32'hFFFF_FFFF,  64'd0);
        send_cmd(OP_READ,    8'd0,   32'd0,          64'd0);
        send_cmd(OP_FIND,    8'd0,   32'd0,          64'd0);
        send_cmd(OP_RELEASE, 8'd0,   32'd1,          64'd0);
        send_cmd(OP_READ,    8'd63,  32'd0,          64'd0);
        send_cmd(OP_STORE,   8'd0,   32'h8000_0000,  64'h8000_0000_0000_0001);
        send_cmd(OP_READ,    8'd0,   32'd0,          64'd0);
        send_cmd(OP_RELEASE, 8'd0,   32'h8000_0000,  64'd0);
    endtask

    task automatic test_full_table();
        logic [OWNER_W-1:0] tenant [3];
        foreach (tenant[k]) tenant[k] = ($urandom & 32'hFFFF_FFFC) | OWNER_W'(k + 1);
        tx_calm = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
            send_cmd(OP_STORE, IDX_W'(i), tenant[i % 3], {$urandom, $urandom});
        end
        tx_calm = 1'b0;
        send_cmd(OP_FIND,    8'd0, 32'd0, 64'd0);
        send_cmd(OP_STORE,   8'd10, tenant[2], 64'h1);
        send_cmd(OP_STORE,   8'd9,  tenant[0], 64'h2);
        send_cmd(OP_READ,    IDX_W'($urandom_range(0, SLOTS - 1)), 32'd0, 64'd0);
        send_cmd(OP_RELEASE, 8'd0, tenant[1], 64'd0);
        send_cmd(OP_FIND,    8'd0, 32'd0, 64'd0);
        send_cmd(OP_RELEASE, 8'd0, tenant[0], 64'd0);
        send_cmd(OP_RELEASE, 8'd0, tenant[2], 64'd0);
        send_cmd(OP_FIND,    8'd0, 32'd0, 64'd0);
    endtask

    task automatic test_random(int count);
        logic [OWNER_W-1:0] pool [6];
        t_op                op;
        logic [IDX_W-1:0]   idx;
        logic [OWNER_W-1:0] who;
        logic [PAY_W-1:0]   data;
        int                 pick;
        foreach (pool[k]) pool[k] = $urandom;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            data = {$urandom, $urandom};
            if ($urandom_range(0, 9) == 0) begin
                op  = t_op'($urandom_range(0, 3));
                idx = IDX_W'($urandom);
                who = $urandom;
            end else begin
                pick = $urandom_range(0, 99);
                op   = t_op'(pick < 40 ? OP_STORE : pick < 70 ? OP_READ :
                             pick < 78 ? OP_RELEASE : OP_FIND);
                idx  = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 15))
                                            : IDX_W'($urandom_range(0, SLOTS + 3));
                pick = $urandom_range(0, 7);
                who  = pick < 6 ? pool[pick] : '0;
            end
            send_cmd(op, idx, who, data);
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    initial begin : result_sink
        int gap;
        @(posedge i_clk);
        forever begin
            gap = rx_calm ? 0 : $urandom_range(0, STALL_MAX);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && o_m_tvalid));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("%0t: result beat with nothing pending: %h", $realtime, o_m_tdata);
                end
            end else begin
                want_result = expected_results.pop_front();
                if (o_m_tdata[2:0] !== want_result.status ||
                    o_m_tdata[10:3] !== want_result.slot ||
                    o_m_tdata[74:11] !== want_result.payload) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: exp st %0d sl %0d pay %h, got st %0d sl %0d pay %h",
                                 $realtime, want_result.status, want_result.slot,
                                 want_result.payload, o_m_tdata[2:0],
                                 o_m_tdata[10:3], o_m_tdata[74:11]);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        foreach (slot_busy[i]) begin
            slot_busy[i]  = 1'b0;
            slot_owner[i] = '0;
            slot_data[i]  = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_table();
        test_random(1050);
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
